// ===== src/pxa_pkg.sv =====
// Shared types and constants for the pixel stack arithmetic block.
// Used by pxa_div and pixel_stack_arithmetic_core; no dependencies.
`default_nettype none

package pxa_pkg;

  localparam int PIX_W          = 16;
  localparam int MAX_IMAGES_DEF = 256;

  typedef enum logic [1:0] {
    FN_SUM  = 2'd0,
    FN_MEAN = 2'd1,
    FN_SUB  = 2'd2,
    FN_DIV  = 2'd3
  } func_t;

  // Request from the core to the serial divider.
  typedef struct packed {
    logic start;
    logic neg;
  } pxa_div_req_t;

  // Finished, signed and saturated quotient.
  typedef struct packed {
    logic                    done;
    logic signed [PIX_W-1:0] quo;
  } pxa_div_rsp_t;

endpackage

`default_nettype wire

// ===== src/pixel_stack_arithmetic_core.sv =====
// Top level of the pixel stack arithmetic block: stacking accumulator,
// subtract path and output register. Depends on pxa_pkg and pxa_div.
`default_nettype none

// Per-pixel arithmetic on signed 16-bit words, chosen per word by func.
// Sum and mean words that are not marked last are added in the accept cycle
// and the next word is taken in the following cycle. Subtract and the last
// sum word go to the emit state, which loads the output register and
// raises out_valid once that register is free. Mean and divide go through
// a restoring divider that yields one quotient bit per cycle for SUM_W bits,
// SUM_W being 16 + clog2(MAX_IMAGES + 1), and then through the emit state.
// A new word is taken once the previous result has moved into the output
// register; that register holds its word until out_ready, and a further
// result then waits in the emit state, stalling the input side. Stacked words
// past MAX_IMAGES are dropped, and dividing by zero gives 0.
module pixel_stack_arithmetic_core import pxa_pkg::*; #(
  parameter int MAX_IMAGES = MAX_IMAGES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              func,
  input  wire logic signed [PIX_W-1:0] pixel_a,
  input  wire logic signed [PIX_W-1:0] pixel_b,
  input  wire logic                    last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [PIX_W-1:0]      pixel_out
);

  localparam int CNT_W = $clog2(MAX_IMAGES + 1);
  localparam int SUM_W = PIX_W + CNT_W;
  localparam int DEN_W = (CNT_W > PIX_W) ? CNT_W : PIX_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t                  state;
  logic signed [SUM_W-1:0] running_sum;
  logic [CNT_W-1:0]        image_count;
  logic signed [PIX_W-1:0] pending;

  func_t                   fn;
  logic                    in_fire;
  logic                    room;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        count_next;
  logic [SUM_W-1:0]        sum_mag;
  logic [PIX_W-1:0]        sum_sat;
  logic signed [PIX_W:0]   diff;
  logic [PIX_W-1:0]        diff_sat;
  logic [PIX_W:0]          a_ext;
  logic [PIX_W:0]          b_ext;
  logic [PIX_W:0]          a_mag;
  logic [PIX_W:0]          b_mag;
  logic [SUM_W-1:0]        num;
  logic [DEN_W-1:0]        den;
  pxa_div_req_t            req;
  pxa_div_rsp_t            rsp;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fn       = func_t'(func);

  always_comb begin
    room       = (image_count < CNT_W'(MAX_IMAGES));
    sum_next   = running_sum;
    count_next = image_count;
    if (room) begin
      sum_next   = running_sum + {{(SUM_W-PIX_W){pixel_a[PIX_W-1]}}, pixel_a};
      count_next = image_count + 1'b1;
    end
    sum_mag = sum_next[SUM_W-1] ? (~sum_next + 1'b1) : sum_next;

    // The sum fits in 16 bits when all bits above bit 14 agree.
    if (sum_next[SUM_W-1:PIX_W-1] == '0 || sum_next[SUM_W-1:PIX_W-1] == '1) begin
      sum_sat = sum_next[PIX_W-1:0];
    end else begin
      sum_sat = sum_next[SUM_W-1] ? 16'h8000 : 16'h7FFF;
    end

    diff = {pixel_a[PIX_W-1], pixel_a} - {pixel_b[PIX_W-1], pixel_b};
    if (diff[PIX_W] == diff[PIX_W-1]) begin
      diff_sat = diff[PIX_W-1:0];
    end else begin
      diff_sat = diff[PIX_W] ? 16'h8000 : 16'h7FFF;
    end

    a_ext = {pixel_a[PIX_W-1], pixel_a};
    b_ext = {pixel_b[PIX_W-1], pixel_b};
    a_mag = pixel_a[PIX_W-1] ? (~a_ext + 1'b1) : a_ext;
    b_mag = pixel_b[PIX_W-1] ? (~b_ext + 1'b1) : b_ext;

    if (fn == FN_DIV) begin
      num     = SUM_W'(a_mag);
      den     = DEN_W'(b_mag[PIX_W-1:0]);
      req.neg = pixel_a[PIX_W-1] ^ pixel_b[PIX_W-1];
    end else begin
      num     = sum_mag;
      den     = DEN_W'(count_next);
      req.neg = sum_next[SUM_W-1];
    end
    req.start = in_fire && ((fn == FN_DIV) || (fn == FN_MEAN && last));
  end

  pxa_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .num (num),
    .den (den),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      running_sum <= '0;
      image_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // In the emit state the output register is reloaded below instead.
      if (out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (fn) inside
              FN_SUB: begin
                pending <= diff_sat;
                state   <= S_EMIT;
              end
              FN_DIV: begin
                state <= S_DIV;
              end
              FN_SUM, FN_MEAN: begin
                if (last) begin
                  running_sum <= '0;
                  image_count <= '0;
                  pending     <= sum_sat;
                  state       <= (fn == FN_SUM) ? S_EMIT : S_DIV;
                end else begin
                  running_sum <= sum_next;
                  image_count <= count_next;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DIV: begin
          if (rsp.done) begin
            pending <= rsp.quo;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            pixel_out <= pending;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    image_count <= CNT_W'(MAX_IMAGES))
    else $error("image count above the stack limit");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_valid && !out_ready |=> state == S_EMIT)
    else $error("pending result overwrote an untaken output word");

  a_sub_emits: assert property (@(posedge clk) disable iff (rst)
    in_fire && fn == FN_SUB |=> state == S_EMIT)
    else $error("subtract word did not go straight to the output stage");

endmodule

`default_nettype wire

// ===== src/pxa_div.sv =====
// Bit-serial restoring divider with sign fix-up and 16-bit saturation.
// Depends on pxa_pkg.
`default_nettype none

module pxa_div import pxa_pkg::*; #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pxa_div_req_t     req,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output pxa_div_rsp_t          rsp
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic              fin;
  logic [STEP_W-1:0] steps;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  divisor;
  logic              neg;

  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  trial;
  logic              qbit;
  logic [DEN_W-1:0]  rem_next;
  logic [PIX_W-1:0]  sat_val;

  // One quotient bit per cycle: the dividend leaves quo at the top while
  // quotient bits enter at the bottom.
  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    trial    = {1'b0, shifted} - {2'b00, divisor};
    qbit     = ~trial[DEN_W+1];
    rem_next = qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_comb begin
    if (divisor == '0) begin
      sat_val = '0;
    end else if (neg) begin
      if (quo > NUM_W'(32768)) begin
        sat_val = 16'h8000;
      end else begin
        sat_val = ~quo[PIX_W-1:0] + 1'b1;
      end
    end else begin
      if (quo > NUM_W'(32767)) begin
        sat_val = 16'h7FFF;
      end else begin
        sat_val = quo[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      steps    <= '0;
      rsp.done <= 1'b0;
      rsp.quo  <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin      <= 1'b0;
        rsp.done <= 1'b1;
        rsp.quo  <= sat_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
      neg     <= req.neg;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], qbit};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire
